### design/amrb_pkg.sv
package amrb_pkg;

  // Bus access codes
  typedef enum logic [1:0] {
    OP_WR_INDEX = 2'd0,
    OP_WR_DATA  = 2'd1,
    OP_RD_INDEX = 2'd2,
    OP_RD_DATA  = 2'd3
  } op_t;

  // Mixer index map
  localparam logic [7:0] IX_RESET      = 8'h00;
  localparam logic [7:0] IX_LEG_VOICE  = 8'h04;
  localparam logic [7:0] IX_LEG_MIC    = 8'h0A;
  localparam logic [7:0] IX_LEG_MASTER = 8'h22;
  localparam logic [7:0] IX_LEG_MIDI   = 8'h26;
  localparam logic [7:0] IX_LEG_CD     = 8'h28;
  localparam logic [7:0] IX_LEG_LINE   = 8'h2E;
  localparam logic [7:0] IX_MASTER     = 8'h30;
  localparam logic [7:0] IX_VOICE      = 8'h32;
  localparam logic [7:0] IX_MIDI       = 8'h34;
  localparam logic [7:0] IX_CD         = 8'h36;
  localparam logic [7:0] IX_LINE       = 8'h38;
  localparam logic [7:0] IX_MIC        = 8'h3A;
  localparam logic [7:0] IX_IRQ        = 8'h80;
  localparam logic [7:0] IX_DMA        = 8'h81;
  localparam logic [7:0] IX_PEND       = 8'h82;

  // Volume range, must lie inside the register bank below
  localparam logic [7:0] VOL_FIRST = 8'd48;
  localparam logic [7:0] VOL_LAST  = 8'd71;

  // Bank of stored mixer registers, 0x30..0x47
  localparam logic [7:0] BANK_FIRST = 8'h30;
  localparam int         BANK_DEPTH = 24;
  localparam logic [7:0] BANK_LAST  = 8'(int'(BANK_FIRST) + BANK_DEPTH - 1);
  localparam int         BANK_AW    = $clog2(BANK_DEPTH);

  // Pending register only ever holds its default
  localparam logic [7:0] PEND_DEFAULT = 8'h40;

  // IRQ/DMA codes swapped on the alternate port pair
  localparam logic [7:0] CODE_A = 8'h02;
  localparam logic [7:0] CODE_B = 8'h08;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       alt;
  } item_t;

  typedef struct packed {
    logic  en;
    item_t item;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] gain;
  } rsp_t;

  // Reset default of a mixer index; zero where there is none
  function automatic logic [7:0] dflt_val(input logic [7:0] ix);
    logic [7:0] v;
    case (ix)
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35: v = 8'hFF;
      8'h3C:                                    v = 8'h1F;
      8'h3D:                                    v = 8'h15;
      8'h3E:                                    v = 8'h0B;
      8'h44, 8'h45, 8'h46, 8'h47:               v = 8'h08;
      IX_PEND:                                  v = PEND_DEFAULT;
      default:                                  v = 8'h00;
    endcase
    return v;
  endfunction

  // floor(v*v*255/1024)
  function automatic logic [7:0] gain_of(input logic [4:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'(v) * 18'd255;
    return p[17:10];
  endfunction

  function automatic logic [7:0] pend_code(input logic [7:0] p);
    logic [7:0] c;
    case (p)
      8'h41:   c = 8'd1;
      8'h42:   c = 8'd2;
      8'h43:   c = 8'd3;
      default: c = 8'h40;
    endcase
    return c;
  endfunction

endpackage

### design/amrb_if.sv
interface amrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data;
  logic       alt_port;

  modport source(output valid, output op, output data, output alt_port, input ready);
  modport sink(input valid, input op, input data, input alt_port, output ready);
endinterface

interface amrb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] gain;

  modport source(output valid, output read_data, output gain, input ready);
  modport sink(input valid, input read_data, input gain, output ready);
endinterface

### design/amrb_regs.sv
module amrb_regs import amrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output rsp_t rsp
);

  localparam logic [BANK_AW-1:0] MIC_OFF = BANK_AW'(IX_MIC - BANK_FIRST);

  logic [7:0] sel_r, sel_nxt;
  logic [7:0] irq_r, irq_nxt;
  logic [7:0] dma_r, dma_nxt;
  logic [7:0] raw_r [BANK_DEPTH];
  logic [7:0] raw_nxt [BANK_DEPTH];
  logic [7:0] exp_r [BANK_DEPTH];
  logic [7:0] exp_nxt [BANK_DEPTH];

  logic               is_vol;
  logic               in_bank_nxt;
  logic [BANK_AW-1:0] off;
  logic [BANK_AW-1:0] off_nxt;
  logic               leg_hit;
  logic [7:0]         leg_base;
  logic [BANK_AW-1:0] leg_off;
  logic [BANK_AW-1:0] leg_off1;
  logic [7:0]         wd;
  logic [7:0]         rd;
  logic [7:0]         leg_sum;
  logic [7:0]         gain;
  logic               wr;

  always_comb begin
    is_vol = (sel_r >= VOL_FIRST) && (sel_r <= VOL_LAST);
    off    = BANK_AW'(sel_r - BANK_FIRST);

    leg_hit  = 1'b1;
    leg_base = IX_VOICE;
    case (sel_r)
      IX_LEG_VOICE:  leg_base = IX_VOICE;
      IX_LEG_MASTER: leg_base = IX_MASTER;
      IX_LEG_MIDI:   leg_base = IX_MIDI;
      IX_LEG_CD:     leg_base = IX_CD;
      IX_LEG_LINE:   leg_base = IX_LINE;
      default:       leg_hit  = 1'b0;
    endcase
    leg_off  = BANK_AW'(leg_base - BANK_FIRST);
    leg_off1 = leg_off + BANK_AW'(1);

    // write remap on the alternate pair
    wd = cmd.item.data;
    if (cmd.item.alt) begin
      if (sel_r == IX_IRQ) begin
        if (wd == CODE_A) wd = CODE_B;
        else if (wd == CODE_B) wd = CODE_A;
      end else if (sel_r == IX_DMA) begin
        if (wd == CODE_B) wd = CODE_A;
      end
    end

    wr      = cmd.en && (cmd.item.op == OP_WR_DATA);
    sel_nxt = sel_r;
    irq_nxt = irq_r;
    dma_nxt = dma_r;
    raw_nxt = raw_r;
    exp_nxt = exp_r;

    if (cmd.en && (cmd.item.op == OP_WR_INDEX)) begin
      sel_nxt = cmd.item.data;
    end

    if (wr) begin
      if (is_vol) begin
        raw_nxt[off] = wd;
        exp_nxt[off] = gain_of(wd[7:3]);
      end else if (leg_hit) begin
        raw_nxt[leg_off]  = {wd[3:0], 4'h0};
        exp_nxt[leg_off]  = {wd[3:0], 4'h0};
        raw_nxt[leg_off1] = {wd[7:4], 4'h0};
        exp_nxt[leg_off1] = {wd[7:4], 4'h0};
      end else begin
        case (sel_r)
          IX_RESET: begin
            // raw bank cleared to defaults; gain only where a default exists
            for (int e = 0; e < BANK_DEPTH; e++) begin
              raw_nxt[e] = dflt_val(8'(int'(BANK_FIRST) + e));
              if (dflt_val(8'(int'(BANK_FIRST) + e)) != 8'h00) begin
                exp_nxt[e] = dflt_val(8'(int'(BANK_FIRST) + e));
              end
            end
          end
          IX_LEG_MIC: begin
            raw_nxt[MIC_OFF] = {5'b0, wd[2:0]};
            exp_nxt[MIC_OFF] = {5'b0, wd[2:0]};
          end
          IX_IRQ:  irq_nxt = wd;
          IX_DMA:  dma_nxt = wd;
          default: ;
        endcase
      end
    end

    // read path
    leg_sum = raw_r[leg_off] + raw_r[leg_off1];
    if (is_vol) begin
      rd = raw_r[off];
    end else if (leg_hit) begin
      rd = {leg_sum[6:0], 1'b0};
    end else begin
      case (sel_r)
        IX_LEG_MIC: rd = raw_r[MIC_OFF];
        IX_IRQ:     rd = irq_r;
        IX_DMA:     rd = dma_r;
        IX_PEND:    rd = pend_code(PEND_DEFAULT);
        default:    rd = 8'h00;
      endcase
    end
    if (cmd.item.alt) begin
      if (sel_r == IX_IRQ) begin
        if (rd == CODE_A) rd = CODE_B;
        else if (rd == CODE_B) rd = CODE_A;
      end else if (sel_r == IX_DMA) begin
        if (rd == CODE_A) rd = CODE_B;
      end
    end

    case (cmd.item.op)
      OP_RD_INDEX: rsp.read_data = sel_r;
      OP_RD_DATA:  rsp.read_data = rd;
      default:     rsp.read_data = 8'h00;
    endcase

    // gain of the index selected once this access is done
    in_bank_nxt = (sel_nxt >= BANK_FIRST) && (sel_nxt <= BANK_LAST);
    off_nxt     = BANK_AW'(sel_nxt - BANK_FIRST);
    if (in_bank_nxt) begin
      gain = exp_nxt[off_nxt];
    end else if (sel_nxt == IX_PEND) begin
      gain = PEND_DEFAULT;
    end else begin
      gain = 8'h00;
    end
    rsp.gain = gain;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 8'h00;
      irq_r <= 8'h00;
      dma_r <= 8'h00;
      for (int e = 0; e < BANK_DEPTH; e++) begin
        raw_r[e] <= dflt_val(8'(int'(BANK_FIRST) + e));
        exp_r[e] <= dflt_val(8'(int'(BANK_FIRST) + e));
      end
    end else begin
      sel_r <= sel_nxt;
      irq_r <= irq_nxt;
      dma_r <= dma_nxt;
      raw_r <= raw_nxt;
      exp_r <= exp_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sel_only_on_index_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.en && (cmd.item.op == OP_WR_INDEX)) |=> $stable(sel_r))
    else $error("selected index moved without an index write");

  a_irq_only_on_irq_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.en && (cmd.item.op == OP_WR_DATA) && (sel_r == IX_IRQ)) |=> $stable(irq_r))
    else $error("irq select moved without a write to its index");

  a_mic_only_on_data_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.en && (cmd.item.op == OP_WR_DATA)) |=> $stable(raw_r[MIC_OFF]))
    else $error("mic register moved without a data write");
`endif

endmodule

### design/audio_mixer_register_block.sv
// Path: an accepted item passes through the input register, then the result register,
// from which the output side takes its result.
// Throughput: one item per cycle while out_ch.ready does not hold it back; the mixer register
// bank is read and written in the same cycle an item leaves the input register.
// Reset: synchronous, active low; clears both stages, loads the mixer defaults.
module audio_mixer_register_block import amrb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  amrb_in_if.sink        in_ch,
  amrb_out_if.source     out_ch
);

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  out_valid_r, out_valid_nxt;
  rsp_t  out_rsp_r;
  logic  in_acc;
  logic  advance;
  cmd_t  cmd;
  rsp_t  rsp;

  // while a result waits, the input register takes an item only if it is empty
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  assign cmd.en   = advance;
  assign cmd.item = s1_item_r;

  amrb_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.op   <= op_t'(in_ch.op);
      s1_item_r.data <= in_ch.data;
      s1_item_r.alt  <= in_ch.alt_port;
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_rsp_r.read_data;
  assign out_ch.gain      = out_rsp_r.gain;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("item left the input register but no result appeared");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("waiting item lost or changed");
`endif

endmodule
